// ===== rtl/core/lkvc_pkg.sv =====
package lkvc_pkg;

   // Width and reset value of the capacity register.
   localparam int CAPACITY_BITS = 7;
   localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 7'd64;

   typedef enum logic {
      ACTION_GET = 1'b0,
      ACTION_PUT = 1'b1
   } action_type;

   // What the directory decided for the request in the input register.
   typedef struct packed {
      logic hit;
      logic evicted;
      logic read_en;
      logic write_en;
   } dir_result_type;

endpackage

// ===== rtl/core/lkvc_value_ram.sv =====
module lkvc_value_ram import lkvc_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    enable,
   input  logic                                    write,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] address,
   input  logic [WIDTH-1:0]                        write_data,
   output logic [WIDTH-1:0]                        read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (enable && write) begin
         mem[address] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && !write) begin
         read_data_ff <= mem[address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/core/lkvc_directory.sv =====
module lkvc_directory import lkvc_pkg::*; #(
   parameter int ENTRIES  = 64,
   parameter int KEY_BITS = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        update,
   input  action_type                                  action,
   input  logic [KEY_BITS-1:0]                         key,
   input  logic [CAPACITY_BITS-1:0]                    capacity,
   output dir_result_type                              result,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] slot,
   output logic [KEY_BITS-1:0]                         evicted_key
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W = $clog2(ENTRIES + 1);

   logic [KEY_BITS-1:0] keys_ff  [ENTRIES];
   logic [IDX_W-1:0]    rank_ff  [ENTRIES];
   logic [IDX_W-1:0]    rank_in  [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;
   logic [ENTRIES-1:0]  valid_in;
   logic [OCC_W-1:0]    occ_ff;
   logic [OCC_W-1:0]    occ_in;

   logic [ENTRIES-1:0]  match;
   logic [ENTRIES-1:0]  oldest;
   logic                is_put;
   logic                hit;
   logic                do_evict;
   logic                do_insert;
   logic [IDX_W-1:0]    hit_idx;
   logic [IDX_W-1:0]    hit_rank;
   logic [IDX_W-1:0]    lru_idx;
   logic [KEY_BITS-1:0] lru_key;
   logic [IDX_W-1:0]    free_idx;
   logic [IDX_W-1:0]    target;
   logic [OCC_W-1:0]    eff_cap;
   logic [OCC_W-1:0]    occ_m1;
   logic [OCC_W-1:0]    limit;

   assign is_put = (action == ACTION_PUT);
   assign occ_m1 = occ_ff - OCC_W'(1);

   always_comb begin
      if (capacity == '0) begin
         eff_cap = OCC_W'(1);
      end else if (32'(capacity) > ENTRIES) begin
         eff_cap = OCC_W'(ENTRIES);
      end else begin
         eff_cap = OCC_W'(capacity);
      end
   end

   // Keys are unique among valid entries, so match and oldest are one-hot
   // at most and the indexes can be formed by OR-ing.
   always_comb begin
      hit_idx  = '0;
      hit_rank = '0;
      lru_idx  = '0;
      lru_key  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (keys_ff[i] == key);
         oldest[i] = valid_ff[i] && (OCC_W'(rank_ff[i]) == occ_m1);
         if (match[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
         if (oldest[i]) begin
            lru_idx = lru_idx | IDX_W'(i);
            lru_key = lru_key | keys_ff[i];
         end
      end
   end

   always_comb begin
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign hit       = |match;
   assign do_evict  = is_put && !hit && (occ_ff >= eff_cap);
   assign do_insert = is_put && !hit && !do_evict;

   always_comb begin
      if (hit) begin
         target = hit_idx;
         limit  = OCC_W'(hit_rank);
      end else if (do_evict) begin
         target = lru_idx;
         limit  = occ_m1;
      end else begin
         target = free_idx;
         limit  = occ_ff;
      end
   end

   // The touched entry becomes rank zero and every valid entry that was
   // more recent than its old rank ages by one.
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (update && (hit || is_put)) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (IDX_W'(i) == target) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (OCC_W'(rank_ff[i]) < limit)) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
         if (do_insert) begin
            valid_in[target] = 1'b1;
            occ_in           = occ_ff + OCC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (update && is_put && !hit) begin
         keys_ff[target] <= key;
      end
   end

   assign result.hit      = hit;
   assign result.evicted  = do_evict;
   assign result.read_en  = hit && !is_put;
   assign result.write_en = is_put;
   assign slot            = target;
   assign evicted_key     = do_evict ? lru_key : '0;

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// Channel | Ports    | Beat contents (lowest bits first)
// request | req_*    | tuser: action; tdata: key, value
// result  | rsp_*    | tuser: hit, evicted; tdata: read_value, evicted_key
// config  | csr_*    | data: capacity
//
// One request is taken every cycle unless the result side stalls; its result beat is
// registered as the request leaves the input register. The rate is set by the directory,
// which compares all keys and updates all recency ranks for the request in that register.
// Reset clears valid bits, ranks and occupancy at once and restores capacity 64.
// While rsp_tready is low the result beat holds and req_tready falls once the
// input register is also full.
module lru_key_value_cache import lkvc_pkg::*; #(
   parameter int ENTRIES    = 64,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   input  logic [0:0]                                   req_tuser,  // action
   input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]     req_tdata,  // key, value
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   output logic [1:0]                                   rsp_tuser,  // hit, evicted
   output logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]     rsp_tdata,  // read_value, evicted_key
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [CAPACITY_BITS-1:0]                     csr_data
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int DATA_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;

   logic [CAPACITY_BITS-1:0] capacity_ff;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   action_type            s1_action_ff;
   logic [KEY_BITS-1:0]   s1_key_ff;
   logic [VALUE_BITS-1:0] s1_value_ff;

   logic                  s2_valid_ff;
   logic                  s2_valid_in;
   logic                  s2_hit_ff;
   logic                  s2_read_ff;
   logic                  s2_evicted_ff;
   logic [KEY_BITS-1:0]   s2_evkey_ff;

   logic                  req_take;
   logic                  s2_take;
   logic                  s1_fire;
   dir_result_type        dir_result;
   logic [IDX_W-1:0]      dir_slot;
   logic [KEY_BITS-1:0]   dir_evkey;
   logic [VALUE_BITS-1:0] ram_rdata;
   logic [VALUE_BITS-1:0] read_value;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   assign s2_take    = !s2_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && s2_take;
   assign req_tready = !s1_valid_ff || s2_take;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in = req_take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s2_take ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= action_type'(req_tuser[0]);
         s1_key_ff    <= req_tdata[KEY_BITS-1:0];
         s1_value_ff  <= req_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
      end
   end

   lkvc_directory #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_directory (
      .clock       (clock),
      .reset       (reset),
      .update      (s1_fire),
      .action      (s1_action_ff),
      .key         (s1_key_ff),
      .capacity    (capacity_ff),
      .result      (dir_result),
      .slot        (dir_slot),
      .evicted_key (dir_evkey)
   );

   lkvc_value_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (VALUE_BITS)
   ) u_value_ram (
      .clock      (clock),
      .enable     (s1_fire && (dir_result.read_en || dir_result.write_en)),
      .write      (dir_result.write_en),
      .address    (dir_slot),
      .write_data (s1_value_ff),
      .read_data  (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_hit_ff     <= dir_result.hit;
         s2_read_ff    <= dir_result.read_en;
         s2_evicted_ff <= dir_result.evicted;
         s2_evkey_ff   <= dir_evkey;
      end
   end

   // The RAM read register holds until the next get hit, so gate it here.
   assign read_value = s2_read_ff ? ram_rdata : '0;

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tuser  = {s2_evicted_ff, s2_hit_ff};
   assign rsp_tdata  = DATA_W'({s2_evkey_ff, read_value});

endmodule

// ===== rtl/core/lkvc_checker.sv =====
module lkvc_checker import lkvc_pkg::*; #(
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_tvalid,
   input logic                                     req_tready,
   input logic [0:0]                               req_tuser,
   input logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] req_tdata,
   input logic                                     rsp_tvalid,
   input logic                                     rsp_tready,
   input logic [1:0]                               rsp_tuser,
   input logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                                     csr_valid,
   input logic                                     csr_ready,
   input logic [CAPACITY_BITS-1:0]                 csr_data
);

   // A hit never evicts.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1])
      else $error("hit and eviction reported together");

   // A miss returns no stored value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[VALUE_BITS-1:0] == '0)
      else $error("miss returned a nonzero value");

   // Without an eviction the evicted key reads zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS] == '0)
      else $error("evicted key set without an eviction");

   // Nothing is presented on the result side right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

endmodule

bind lru_key_value_cache lkvc_checker #(
   .KEY_BITS   (KEY_BITS),
   .VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (.*);
